@@ design/binary_trie_prefix_match_assert.svh @@
// Assertion macros shared by the trie engine.
// Each macro expects a clock named clk and a synchronous reset named rst
// in the scope where it is used.
`ifndef BINARY_TRIE_PREFIX_MATCH_ASSERT_SVH
`define BINARY_TRIE_PREFIX_MATCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/btpm_pkg.sv @@
`timescale 1ns / 1ps

package btpm_pkg;

  // Default sizing of the engine.
  localparam int NODES_DEF      = 4096;
  localparam int PORT_WIDTH_DEF = 16;
  localparam int ADDR_BITS_DEF  = 32;

  // Fixed widths of the beat fields.
  localparam int IP_W       = 32;
  localparam int LEN_W      = 6;
  localparam int PORT_IN_W  = 16;
  localparam int PORT_OUT_W = 16;
  localparam int STATUS_W   = 2;

  // Operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  found;
    logic [PORT_OUT_W-1:0] port_out;
    status_t               status;
  } result_t;

endpackage

@@ design/btpm_node_mem.sv @@
`timescale 1ns / 1ps

// Single-port node store with a registered read.
module btpm_node_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 41
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // The read data holds its value until the next read, so a node fetched
  // during a walk stays available while later writes go on.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ design/btpm_out_reg.sv @@
`timescale 1ns / 1ps

// Result register that holds one beat for the downstream receiver.
module btpm_out_reg import btpm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load_valid,
  output logic    load_ready,
  input  result_t load_res,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  assign load_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_valid && load_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      out_res <= load_res;
    end
  end

endmodule

@@ design/binary_trie_prefix_match.sv @@
`timescale 1ns / 1ps
// Longest-prefix-match engine on a one-bit-per-level binary trie.
// Input channel (in_valid / in_stall) carries one request per beat: a lookup
// of ip, or an insert of the first pfx_len bits of ip with port. The
// output channel (out_valid / out_stall) returns exactly one result beat per
// request: found and port_out for a lookup, status (ok, duplicate, full) for
// an insert.
// A request walks the trie one level per cycle through the single-port node
// store, and an insert then writes one new node per cycle. A request ends
// at depth ADDR_BITS at most, and the next one is taken only after its done
// state; a zero-length insert goes straight from acceptance to done.
// The result beat is presented in the same cycle that in_stall falls; in_stall
// is high while a request is at work.
// Reset empties the trie: the root links are registers cleared at once and
// the allocation counter returns to one, so no clearing pass is needed and
// the first request can be taken in the cycle after reset.
// The result sits in an output register; a stalled receiver does not stop
// the next request from being taken, but that request waits at its end
// until the register is free.
`include "binary_trie_prefix_match_assert.svh"

module binary_trie_prefix_match import btpm_pkg::*; #(
  parameter int NODES      = NODES_DEF,
  parameter int PORT_WIDTH = PORT_WIDTH_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [IP_W-1:0]       ip,
  input  logic [LEN_W-1:0]      pfx_len,
  input  logic [PORT_IN_W-1:0]  port,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  found,
  output logic [PORT_OUT_W-1:0] port_out,
  output logic [STATUS_W-1:0]   status
);

  localparam int NODE_W  = $clog2(NODES);
  localparam int CNT_W   = $clog2(NODES + 1);
  localparam int DEPTH_W = $clog2(ADDR_BITS + 1);
  localparam int SUM_W   = ((CNT_W > DEPTH_W) ? CNT_W : DEPTH_W) + 1;
  localparam int ENTRY_W = 2 * NODE_W + 1 + PORT_WIDTH;

  // A child link of zero means no child, since the allocation counter starts at one.
  typedef struct packed {
    logic [NODE_W-1:0]     link0;
    logic [NODE_W-1:0]     link1;
    logic                  valid;
    logic [PORT_WIDTH-1:0] port;
  } entry_t;

  state_t state, state_next;

  // Request held for the length of the walk.
  logic                  op_r;
  logic [ADDR_BITS-1:0]  addr_sh;
  logic [DEPTH_W-1:0]    len_r;
  logic [PORT_WIDTH-1:0] port_r;

  // Walk position and best match so far.
  logic [DEPTH_W-1:0]    depth;
  logic                  at_root;
  logic [NODE_W-1:0]     cur;
  logic                  hit;
  logic [PORT_WIDTH-1:0] best;

  // Trie bookkeeping: allocation counter and the root, which lives in
  // registers so that reset clears it without touching the store.
  logic [CNT_W-1:0]      nfree;
  logic [NODE_W-1:0]     root_link0;
  logic [NODE_W-1:0]     root_link1;

  result_t res;
  logic    res_load;
  logic    res_ready;
  result_t out_res;

  // Node store port.
  logic               mem_en;
  logic               mem_we;
  logic [NODE_W-1:0]  mem_addr;
  entry_t             mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata_bits;
  entry_t             mem_rdata;

  // Per-cycle decode of the current node.
  entry_t                node;
  logic                  cur_bit;
  logic                  nxt_bit;
  logic [NODE_W-1:0]     child;
  logic [DEPTH_W-1:0]    limit;
  logic                  walk_end;
  logic                  miss;
  logic                  hit_now;
  logic [PORT_WIDTH-1:0] best_now;
  logic [DEPTH_W-1:0]    need;
  logic                  store_full;
  logic                  last;
  logic [NODE_W-1:0]     fresh;
  logic [NODE_W-1:0]     fresh_succ;
  logic [DEPTH_W-1:0]    len_sat;
  logic                  in_take;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && (state == S_IDLE);

  // Prefix lengths beyond the address width behave as the full width.
  assign len_sat = (pfx_len > LEN_W'(ADDR_BITS)) ? DEPTH_W'(ADDR_BITS)
                                                  : DEPTH_W'(pfx_len);

  assign mem_rdata = entry_t'(mem_rdata_bits);

  // The root is never a match itself: a zero-length insert changes nothing.
  always_comb begin
    if (at_root) begin
      node.link0 = root_link0;
      node.link1 = root_link1;
      node.valid = 1'b0;
      node.port  = '0;
    end else begin
      node = mem_rdata;
    end
  end

  // addr_sh is shifted left once per level, so its top bit selects the
  // branch taken from the current node.
  assign cur_bit  = addr_sh[ADDR_BITS-1];
  assign nxt_bit  = addr_sh[ADDR_BITS-2];
  assign child    = cur_bit ? node.link1 : node.link0;
  assign limit    = (op_r == OP_INSERT) ? len_r : DEPTH_W'(ADDR_BITS);
  assign walk_end = (depth == limit);
  assign miss     = (child == '0);
  assign hit_now  = hit || node.valid;
  assign best_now = node.valid ? node.port : best;

  // The insert is refused when the missing tail does not fit in the pool.
  assign need       = len_r - depth;
  assign store_full = (SUM_W'(nfree) + SUM_W'(need)) > SUM_W'(NODES);

  assign last       = (depth == DEPTH_W'(len_r - 1'b1));
  assign fresh      = nfree[NODE_W-1:0];
  assign fresh_succ = NODE_W'(nfree + 1'b1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if ((op == OP_INSERT) && (len_sat == '0)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (walk_end || miss) begin
          if ((op_r == OP_INSERT) && !walk_end && !store_full) begin
            state_next = S_ALLOC;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ALLOC: begin
        if (last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Node store control and result hand-off.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = child;
    mem_wdata = node;
    res_load  = 1'b0;
    case (state)
      S_WALK: begin
        if (!(walk_end || miss)) begin
          mem_en   = 1'b1;
          mem_addr = child;
        end else if (op_r == OP_INSERT) begin
          if (walk_end) begin
            // The prefix path exists: mark its last node unless it is taken.
            if (!node.valid) begin
              mem_en          = 1'b1;
              mem_we          = 1'b1;
              mem_addr        = cur;
              mem_wdata.valid = 1'b1;
              mem_wdata.port  = port_r;
            end
          end else if (!store_full && !at_root) begin
            // Hook the first new node onto the last existing one.
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = cur;
            if (cur_bit) begin
              mem_wdata.link1 = fresh;
            end else begin
              mem_wdata.link0 = fresh;
            end
          end
        end
      end
      S_ALLOC: begin
        // Each new node is written whole; all but the last point at the
        // node allocated right after it.
        mem_en          = 1'b1;
        mem_we          = 1'b1;
        mem_addr        = fresh;
        mem_wdata.link0 = (!last && !nxt_bit) ? fresh_succ : '0;
        mem_wdata.link1 = (!last && nxt_bit) ? fresh_succ : '0;
        mem_wdata.valid = last;
        mem_wdata.port  = last ? port_r : '0;
      end
      S_DONE: begin
        res_load = 1'b1;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nfree      <= CNT_W'(1);
      root_link0 <= '0;
      root_link1 <= '0;
    end else begin
      state <= state_next;
      if (state == S_ALLOC) begin
        nfree <= nfree + 1'b1;
      end
      if ((state == S_WALK) && miss && !walk_end && (op_r == OP_INSERT) &&
          !store_full && at_root) begin
        if (cur_bit) begin
          root_link1 <= fresh;
        end else begin
          root_link0 <= fresh;
        end
      end
    end
  end

  // Walk datapath and result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          op_r         <= op;
          addr_sh      <= ip[ADDR_BITS-1:0];
          len_r        <= len_sat;
          port_r       <= PORT_WIDTH'(port);
          depth        <= '0;
          at_root      <= 1'b1;
          hit          <= 1'b0;
          best         <= '0;
          res.found    <= 1'b0;
          res.port_out <= '0;
          res.status   <= ST_OK;
        end
      end
      S_WALK: begin
        hit  <= hit_now;
        best <= best_now;
        if (!(walk_end || miss)) begin
          depth   <= depth + 1'b1;
          addr_sh <= {addr_sh[ADDR_BITS-2:0], 1'b0};
          cur     <= child;
          at_root <= 1'b0;
        end else if (op_r == OP_INSERT) begin
          if (walk_end) begin
            res.status <= node.valid ? ST_DUP : ST_OK;
          end else if (store_full) begin
            res.status <= ST_FULL;
          end
        end else begin
          res.found    <= hit_now;
          res.port_out <= PORT_OUT_W'(best_now);
        end
      end
      S_ALLOC: begin
        depth   <= depth + 1'b1;
        addr_sh <= {addr_sh[ADDR_BITS-2:0], 1'b0};
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

  btpm_node_mem #(
    .DEPTH  (NODES),
    .DATA_W (ENTRY_W)
  ) u_node_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata_bits)
  );

  btpm_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (res_load),
    .load_ready (res_ready),
    .load_res   (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign found    = out_res.found;
  assign port_out = out_res.port_out;
  assign status   = out_res.status;

  // An allocation is only started when the whole tail fits in the pool.
  `BTPM_ASSERT_IMP(a_alloc_in_pool, state == S_ALLOC, nfree < CNT_W'(NODES), "alloc past pool")
  // Every allocation cycle consumes exactly one node.
  `BTPM_ASSERT_NXT(a_alloc_step, state == S_ALLOC, nfree == $past(nfree) + 1'b1, "alloc count")
  // The walk never goes deeper than the address or the prefix allows.
  `BTPM_ASSERT_IMP(a_walk_depth, state == S_WALK, depth <= limit, "walk too deep")
  // A result beat only appears after a request has finished.
  `BTPM_ASSERT_IMP(a_result_origin, $rose(out_valid), $past(state) == S_DONE, "stray result")

endmodule
